// ===== sv/ncas_pkg.sv =====
// Shared constants, types and codes of the nearest centroid assign unit.
package ncas_pkg;

  localparam int MAX_CENTROIDS = 16;
  localparam int MAX_DIMS      = 16;
  localparam int SAMPLE_WIDTH  = 16;

  localparam int CIDX_W   = $clog2(MAX_CENTROIDS);
  localparam int DIDX_W   = $clog2(MAX_DIMS);
  localparam int CADDR_W  = CIDX_W + DIDX_W;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_W     = 2 * SAMPLE_WIDTH;
  localparam int DIST_W   = 36;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic OP_CENTROID = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // One centroid slot issued to the distance pipeline
  typedef struct packed {
    logic              vld;
    logic [CIDX_W-1:0] c;
    logic              first;
    logic              last;
  } issue_t;

  // Pipeline status back to the sequencer
  typedef struct packed {
    logic              busy;
    logic [CIDX_W-1:0] best_idx;
    logic [DIST_W-1:0] best_dist;
  } pipe_stat_t;

endpackage

// ===== sv/ncas_centroid_mem.sv =====
// Centroid element store: one write port, one registered read port.
module ncas_centroid_mem
  import ncas_pkg::*;
(
  input  logic                    clk,
  input  logic                    we,
  input  logic [CADDR_W-1:0]      waddr,
  input  logic [SAMPLE_WIDTH-1:0] wdata,
  input  logic [CADDR_W-1:0]      raddr,
  output logic [SAMPLE_WIDTH-1:0] rdata
);

  logic [SAMPLE_WIDTH-1:0] mem [MAX_CENTROIDS*MAX_DIMS];
  logic [SAMPLE_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ncas_acc_mem.sv =====
// Distance accumulator store with per-entry valid bits; unwritten entries read zero.
module ncas_acc_mem
  import ncas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [CIDX_W-1:0] waddr,
  input  logic [DIST_W-1:0] wdata,
  input  logic [CIDX_W-1:0] raddr,
  output logic [DIST_W-1:0] rdata
);

  logic [DIST_W-1:0]        mem [MAX_CENTROIDS];
  logic [MAX_CENTROIDS-1:0] valid_r;
  logic [DIST_W-1:0]        rdata_r;
  logic                     rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvld_r <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// ===== sv/ncas_dist_pipe.sv =====
// Two-stage squared-difference, saturating accumulate and running minimum.
module ncas_dist_pipe
  import ncas_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  issue_t                  issue,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic [SAMPLE_WIDTH-1:0] cent_rdata,
  input  logic [DIST_W-1:0]       acc_rdata,
  output logic                    acc_we,
  output logic [CIDX_W-1:0]       acc_waddr,
  output logic [DIST_W-1:0]       acc_wdata,
  output pipe_stat_t              stat
);

  issue_t                  s1_r, s2_r;
  logic [SQ_W-1:0]         sq_r;
  logic [DIST_W-1:0]       base_r;
  logic [CIDX_W-1:0]       best_idx_r;
  logic [DIST_W-1:0]       best_dist_r;

  logic signed [SAMPLE_WIDTH:0] diff;
  logic [SAMPLE_WIDTH:0]        diff_neg;
  logic [SAMPLE_WIDTH-1:0]      absd;
  logic [DIST_W:0]              sum;
  logic [DIST_W-1:0]            sum_sat;
  logic                         take_best;

  // stage 1: memory data arrives, square the difference
  always_comb begin
    diff     = $signed({sample[SAMPLE_WIDTH-1], sample})
             - $signed({cent_rdata[SAMPLE_WIDTH-1], cent_rdata});
    diff_neg = (SAMPLE_WIDTH+1)'(-diff);
    absd     = diff[SAMPLE_WIDTH] ? diff_neg[SAMPLE_WIDTH-1:0]
                                  : diff[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= issue.vld;
      s2_r.vld <= s1_r.vld;
    end
    s1_r.c     <= issue.c;
    s1_r.first <= issue.first;
    s1_r.last  <= issue.last;
    s2_r.c     <= s1_r.c;
    s2_r.first <= s1_r.first;
    s2_r.last  <= s1_r.last;
    sq_r       <= SQ_W'(absd) * SQ_W'(absd);
    base_r     <= s1_r.first ? '0 : acc_rdata;
  end

  // stage 2: saturating add, write back, track the minimum
  always_comb begin
    sum       = {1'b0, base_r} + (DIST_W+1)'(sq_r);
    sum_sat   = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
    take_best = s2_r.vld && s2_r.last
             && ((s2_r.c == '0) || (sum_sat < best_dist_r));
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_idx_r  <= s2_r.c;
      best_dist_r <= sum_sat;
    end
  end

  assign acc_we         = s2_r.vld;
  assign acc_waddr      = s2_r.c;
  assign acc_wdata      = sum_sat;
  assign stat.busy      = s1_r.vld | s2_r.vld;
  assign stat.best_idx  = best_idx_r;
  assign stat.best_dist = best_dist_r;

endmodule

// ===== sv/nearest_centroid_assign_unit.sv =====
// Top level of the nearest centroid assign unit: sequencer, registers, result register.
//
// The unit keeps a table of up to 16 centroids of up to 16 signed 16-bit
// elements and, as a sample vector streams in one element per item in
// dimension order, adds each element's squared difference into one
// accumulator per active centroid (saturating at 2^36-1); dimension 0 starts
// the sums afresh. The item for the last configured dimension yields the
// nearest centroid index and its squared distance, ties going to the lower
// index. A sample item walks the centroid memory one read per active
// centroid through its single read port, and no new item is taken until
// that pass ends; the item for the last dimension then hands its result
// to the output register. The result register lets the next item in while
// a result waits. No clearing pass after reset: the accumulators carry
// valid bits, and centroid entries must be written before a sample uses them.
// Counts of 0 act as 1 and counts above 16 act as 16.
module nearest_centroid_assign_unit
  import ncas_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // item input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [CIDX_W-1:0]       in_centroid_index,
  input  logic [DIDX_W-1:0]       in_dim_index,
  input  logic signed [SAMPLE_WIDTH-1:0] in_value,
  // result output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CIDX_W-1:0]       out_nearest_index,
  output logic [DIST_W-1:0]       out_nearest_distance,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CNT_W-1:0]        cfg_data
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        ccount_r, dcount_r;
  logic [CIDX_W-1:0]       nc_last;
  logic [DIDX_W-1:0]       nd_last;
  logic [CIDX_W-1:0]       cnt_r, cnt_nxt;
  logic [DIDX_W-1:0]       dim_r;
  logic [SAMPLE_WIDTH-1:0] sample_r;
  logic                    first_r, last_r;

  logic                    out_valid_r;
  logic [CIDX_W-1:0]       out_idx_r;
  logic [DIST_W-1:0]       out_dist_r;

  logic                    in_acc;
  logic                    start;
  logic                    emit;
  issue_t                  issue;
  pipe_stat_t              stat;

  logic [SAMPLE_WIDTH-1:0] cent_rdata;
  logic [DIST_W-1:0]       acc_rdata;
  logic                    acc_we;
  logic [CIDX_W-1:0]       acc_waddr;
  logic [DIST_W-1:0]       acc_wdata;

  // last active centroid / dimension, with out-of-range counts clamped
  always_comb begin
    if (ccount_r == '0) begin
      nc_last = '0;
    end else if (ccount_r > CNT_W'(MAX_CENTROIDS)) begin
      nc_last = CIDX_W'(MAX_CENTROIDS - 1);
    end else begin
      nc_last = CIDX_W'(ccount_r - CNT_W'(1));
    end
    if (dcount_r == '0) begin
      nd_last = '0;
    end else if (dcount_r > CNT_W'(MAX_DIMS)) begin
      nd_last = DIDX_W'(MAX_DIMS - 1);
    end else begin
      nd_last = DIDX_W'(dcount_r - CNT_W'(1));
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r <= CNT_W'(MAX_CENTROIDS);
      dcount_r <= CNT_W'(MAX_DIMS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTROID_COUNT:  ccount_r <= cfg_data;
        REG_DIMENSION_COUNT: dcount_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // items are taken only between passes; a sample beyond the count is dropped
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && (in_op == OP_SAMPLE) && (in_dim_index <= nd_last);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_RUN;
      ST_RUN:   if (cnt_r == nc_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!stat.busy) state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue.vld   = 1'b0;
    issue.c     = cnt_r;
    issue.first = first_r;
    issue.last  = last_r;
    cnt_nxt     = cnt_r;
    emit        = 1'b0;
    unique case (state_r)
      ST_IDLE:  cnt_nxt = '0;
      ST_RUN: begin
        issue.vld = 1'b1;
        cnt_nxt   = cnt_r + CIDX_W'(1);
      end
      ST_DRAIN: ;
      ST_EMIT:  emit = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // sample item held for the length of its pass
  always_ff @(posedge clk) begin
    if (start) begin
      dim_r    <= in_dim_index;
      sample_r <= in_value;
      first_r  <= (in_dim_index == '0);
      last_r   <= (in_dim_index == nd_last);
    end
  end

  ncas_centroid_mem u_cent (
    .clk   (clk),
    .we    (in_acc && (in_op == OP_CENTROID)),
    .waddr ({in_centroid_index, in_dim_index}),
    .wdata (in_value),
    .raddr ({cnt_r, dim_r}),
    .rdata (cent_rdata)
  );

  ncas_acc_mem u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (cnt_r),
    .rdata (acc_rdata)
  );

  ncas_dist_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .sample     (sample_r),
    .cent_rdata (cent_rdata),
    .acc_rdata  (acc_rdata),
    .acc_we     (acc_we),
    .acc_waddr  (acc_waddr),
    .acc_wdata  (acc_wdata),
    .stat       (stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= stat.best_idx;
      out_dist_r <= stat.best_dist;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;

endmodule
